// File: hw/rtl/emp_pkg.sv
package emp_pkg;

   localparam int ENERGY_WIDTH = 32;
   localparam int TIME_WIDTH   = 64;
   localparam int POWER_WIDTH  = 14;
   localparam int SHIFT_WIDTH  = 5;

   // Energy delta times the scale factor fits in this many bits.
   localparam int NUM_WIDTH    = ENERGY_WIDTH + POWER_WIDTH;

   localparam logic [POWER_WIDTH-1:0] POWER_SCALE = 14'd10000;
   localparam logic [POWER_WIDTH-1:0] POWER_MAX   = 14'd9999;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = SHIFT_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_METER_ENABLED     = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENERGY_UNIT_SHIFT = 1'd1;

endpackage

// File: hw/rtl/emp_req_if.sv
interface emp_req_if;
   logic                              valid;
   logic                              ready;
   logic [emp_pkg::ENERGY_WIDTH-1:0]  energy_count;
   logic [emp_pkg::TIME_WIDTH-1:0]    time_ms;

   modport source (output valid, output energy_count, output time_ms, input ready);
   modport sink   (input valid, input energy_count, input time_ms, output ready);
endinterface

// File: hw/rtl/emp_rsp_if.sv
interface emp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [emp_pkg::POWER_WIDTH-1:0]  power_tenths_watts;

   modport source (output valid, output power_tenths_watts, input ready);
   modport sink   (input valid, input power_tenths_watts, output ready);
endinterface

// File: hw/rtl/emp_csr_if.sv
interface emp_csr_if;
   logic                                valid;
   logic                                ready;
   logic [emp_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [emp_pkg::CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/energy_counter_power_meter_top.sv
// Channel   Port     Direction  Contents
// request   req_ch   in         energy_count[31:0], time_ms[63:0]
// response  rsp_ch   out        power_tenths_watts[13:0]
// config    csr_ch   in         index (0 enable, 1 unit shift), data[4:0]
//
// A computed request steps through the multiply, the shift state that doubles
// the divisor once per unit of the unit shift, a check, the restoring divide at
// one quotient bit per cycle, and the finish and done states; the next request
// is taken once the machine is back in idle. Disabled, priming, zero-interval
// and zero-shift requests go straight to done. Reset is synchronous and clears
// the stored sample, the primed flag, the settings, the state and the response
// valid, not the datapath. A stalled response holds in its output register;
// the next request is taken meanwhile and waits at its end for it to free.
module energy_counter_power_meter_top (
   input  logic         clock,
   input  logic         reset,
   emp_req_if.sink      req_ch,
   emp_rsp_if.source    rsp_ch,
   emp_csr_if.sink      csr_ch
);
   import emp_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL    = 3'd1;
   localparam logic [2:0] ST_SHIFT  = 3'd2;
   localparam logic [2:0] ST_CHECK  = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   localparam int CNT_WIDTH = $clog2(NUM_WIDTH);

   logic [2:0]              state_ff, state_in;
   logic                    enabled_ff, enabled_in;
   logic [SHIFT_WIDTH-1:0]  shift_ff, shift_in;
   logic                    primed_ff, primed_in;
   logic [ENERGY_WIDTH-1:0] prev_energy_ff, prev_energy_in;
   logic [TIME_WIDTH-1:0]   prev_time_ff, prev_time_in;
   logic [ENERGY_WIDTH-1:0] delta_e_ff, delta_e_in;
   logic [TIME_WIDTH-1:0]   denom_ff, denom_in;
   logic [NUM_WIDTH-1:0]    acc_ff, acc_in;
   logic [TIME_WIDTH-1:0]   rem_ff, rem_in;
   logic [POWER_WIDTH-1:0]  quot_ff, quot_in;
   logic                    ovf_ff, ovf_in;
   logic [CNT_WIDTH-1:0]    cnt_ff, cnt_in;
   logic [POWER_WIDTH-1:0]  result_ff, result_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [POWER_WIDTH-1:0]  rsp_power_ff, rsp_power_in;

   logic                    req_fire;
   logic                    csr_fire;
   logic [ENERGY_WIDTH-1:0] delta_e;
   logic [TIME_WIDTH-1:0]   delta_t;
   logic [TIME_WIDTH:0]     trial;
   logic [TIME_WIDTH:0]     diff;
   logic                    quot_bit;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_fire     = csr_ch.valid && csr_ch.ready;

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.power_tenths_watts = rsp_power_ff;

   assign delta_e = req_ch.energy_count - prev_energy_ff;
   assign delta_t = req_ch.time_ms - prev_time_ff;

   // The partial remainder stays below the divisor, so one shifted-in bit
   // makes a 65-bit trial value.
   assign trial    = {rem_ff, acc_ff[NUM_WIDTH-1]};
   assign diff     = trial - {1'b0, denom_ff};
   assign quot_bit = !diff[TIME_WIDTH];

   always_comb begin
      enabled_in = enabled_ff;
      shift_in   = shift_ff;
      if (csr_fire) begin
         case (csr_ch.index)
            CSR_METER_ENABLED:     enabled_in = csr_ch.data[0];
            CSR_ENERGY_UNIT_SHIFT: shift_in   = csr_ch.data[SHIFT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      primed_in      = primed_ff;
      prev_energy_in = prev_energy_ff;
      prev_time_in   = prev_time_ff;
      delta_e_in     = delta_e_ff;
      denom_in       = denom_ff;
      acc_in         = acc_ff;
      rem_in         = rem_ff;
      quot_in        = quot_ff;
      ovf_in         = ovf_ff;
      cnt_in         = cnt_ff;
      result_in      = result_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_power_in   = rsp_power_ff;

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               result_in = '0;
               state_in  = ST_DONE;
               if (enabled_ff) begin
                  prev_energy_in = req_ch.energy_count;
                  prev_time_in   = req_ch.time_ms;
                  primed_in      = 1'b1;
                  if (primed_ff && delta_t != '0 && shift_ff != '0) begin
                     delta_e_in = delta_e;
                     denom_in   = delta_t;
                     acc_in     = '0;
                     cnt_in     = CNT_WIDTH'(POWER_WIDTH - 1);
                     state_in   = ST_MUL;
                  end
               end
            end
         end
         // Shift-and-add over the bits of the scale factor, high bit first.
         ST_MUL: begin
            acc_in = {acc_ff[NUM_WIDTH-2:0], 1'b0}
                     + (POWER_SCALE[cnt_ff[$clog2(POWER_WIDTH)-1:0]]
                        ? NUM_WIDTH'(delta_e_ff) : NUM_WIDTH'(0));
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               cnt_in   = CNT_WIDTH'(shift_ff);
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (cnt_ff == '0) begin
               state_in = ST_CHECK;
            end else begin
               denom_in = {denom_ff[TIME_WIDTH-2:0], 1'b0};
               cnt_in   = cnt_ff - 1'b1;
            end
         end
         ST_CHECK: begin
            if (denom_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               rem_in   = '0;
               quot_in  = '0;
               ovf_in   = 1'b0;
               cnt_in   = CNT_WIDTH'(NUM_WIDTH - 1);
               state_in = ST_DIV;
            end
         end
         // Only the low quotient bits are kept; any bit shifted out above
         // them means the result saturates.
         ST_DIV: begin
            rem_in  = quot_bit ? diff[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
            acc_in  = {acc_ff[NUM_WIDTH-2:0], 1'b0};
            quot_in = {quot_ff[POWER_WIDTH-2:0], quot_bit};
            ovf_in  = ovf_ff || quot_ff[POWER_WIDTH-1];
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            result_in = (ovf_ff || quot_ff > POWER_MAX) ? POWER_MAX : quot_ff;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_power_in = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         enabled_ff     <= 1'b0;
         shift_ff       <= '0;
         primed_ff      <= 1'b0;
         prev_energy_ff <= '0;
         prev_time_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         enabled_ff     <= enabled_in;
         shift_ff       <= shift_in;
         primed_ff      <= primed_in;
         prev_energy_ff <= prev_energy_in;
         prev_time_ff   <= prev_time_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_e_ff   <= delta_e_in;
      denom_ff     <= denom_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      ovf_ff       <= ovf_in;
      cnt_ff       <= cnt_in;
      result_ff    <= result_in;
      rsp_power_ff <= rsp_power_in;
   end

endmodule

// File: dv/power_meter_checker.sv
`timescale 1ns / 1ps

module power_meter_checker
   import emp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   emp_req_if   req_ch,
   emp_rsp_if   rsp_ch,
   emp_csr_if   csr_ch,
   output int   error_count,
   output int   outstanding
);

   logic [POWER_WIDTH-1:0]  expected_power_q[$];

   logic                    meter_on;
   logic [SHIFT_WIDTH-1:0]  unit_shift;
   logic [ENERGY_WIDTH-1:0] stored_energy;
   logic [TIME_WIDTH-1:0]   stored_time;
   logic                    is_primed;

   function automatic logic [POWER_WIDTH-1:0] average_power(
      input logic [ENERGY_WIDTH-1:0] delta_e,
      input logic [TIME_WIDTH-1:0]   delta_t,
      input logic [SHIFT_WIDTH-1:0]  shift
   );
      logic [63:0] denom;
      logic [63:0] quot;
      if (delta_t == '0 || shift == '0) begin
         return '0;
      end
      // The shifted interval is taken modulo 2^64 and may wrap to zero.
      denom = delta_t << shift;
      if (denom == '0) begin
         return '0;
      end
      quot = (64'(delta_e) * 64'(POWER_SCALE)) / denom;
      if (quot > 64'(POWER_MAX)) begin
         return POWER_MAX;
      end
      return quot[POWER_WIDTH-1:0];
   endfunction

   always @(posedge clock) begin : monitor
      logic                   req_fire;
      logic                   rsp_fire;
      logic [POWER_WIDTH-1:0] want;
      req_fire = req_ch.valid && req_ch.ready;
      rsp_fire = rsp_ch.valid && rsp_ch.ready;
      if (reset) begin
         expected_power_q.delete();
         meter_on      = 1'b0;
         unit_shift    = '0;
         stored_energy = '0;
         stored_time   = '0;
         is_primed     = 1'b0;
         error_count  <= 0;
         outstanding  <= 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == CSR_METER_ENABLED) begin
               meter_on = csr_ch.data[0];
            end else if (csr_ch.index == CSR_ENERGY_UNIT_SHIFT) begin
               unit_shift = csr_ch.data[SHIFT_WIDTH-1:0];
            end
         end

         // Responses are checked before this edge's request is queued, since a
         // response can never belong to a request taken at the same edge.
         if (rsp_fire) begin
            if (expected_power_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0d",
                        $time, rsp_ch.power_tenths_watts);
               error_count <= error_count + 1;
            end else begin
               want = expected_power_q.pop_front();
               if (rsp_ch.power_tenths_watts !== want) begin
                  $display("%0t: power_tenths_watts mismatch, expected %0d, actual %0d",
                           $time, want, rsp_ch.power_tenths_watts);
                  error_count <= error_count + 1;
               end
            end
         end

         if (req_fire) begin
            want = '0;
            if (meter_on) begin
               if (is_primed) begin
                  want = average_power(req_ch.energy_count - stored_energy,
                                       req_ch.time_ms - stored_time, unit_shift);
               end
               stored_energy = req_ch.energy_count;
               stored_time   = req_ch.time_ms;
               is_primed     = 1'b1;
            end
            expected_power_q.push_back(want);
         end

         outstanding <= outstanding + int'(req_fire) - int'(rsp_fire);
      end
   end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import emp_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;

   typedef enum int {
      RSP_ALWAYS,
      RSP_COIN,
      RSP_SPARSE,
      RSP_STALLS
   } rsp_mode_type;

   logic clock;
   logic reset;

   emp_req_if req_if ();
   emp_rsp_if rsp_if ();
   emp_csr_if csr_if ();

   int                      mismatches;
   int                      in_flight;
   int                      burst_left;
   int                      idle_cycles;
   logic [SHIFT_WIDTH-1:0]  stim_shift;
   logic [ENERGY_WIDTH-1:0] last_energy;
   logic [TIME_WIDTH-1:0]   last_time;

   energy_counter_power_meter_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   power_meter_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_ch      (csr_if),
      .error_count (mismatches),
      .outstanding (in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The response side keeps each stall pattern for a random stretch.
   initial begin : rsp_stall
      rsp_mode_type mode;
      int           stretch;
      int           stall_left;
      mode       = RSP_ALWAYS;
      stretch    = 0;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stretch == 0) begin
            mode    = rsp_mode_type'($urandom_range(0, 3));
            stretch = $urandom_range(20, 300);
         end
         stretch--;
         case (mode)
            RSP_ALWAYS: begin
               rsp_if.ready <= 1'b1;
            end
            RSP_COIN: begin
               rsp_if.ready <= 1'($urandom_range(0, 1));
            end
            RSP_SPARSE: begin
               rsp_if.ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               if (stall_left > 0) begin
                  rsp_if.ready <= 1'b0;
                  stall_left--;
               end else begin
                  rsp_if.ready <= 1'b1;
                  if ($urandom_range(0, 7) == 0) begin
                     stall_left = $urandom_range(5, 40);
                  end
               end
            end
         endcase
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("status: fail");
      $finish;
   end

   task automatic send_sample(input logic [ENERGY_WIDTH-1:0] energy,
                              input logic [TIME_WIDTH-1:0] stamp);
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 120)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_if.valid        <= 1'b1;
      req_if.energy_count <= energy;
      req_if.time_ms      <= stamp;
      do @(posedge clock); while (!req_if.ready);
      last_energy = energy;
      last_time   = stamp;
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic enable, input logic [SHIFT_WIDTH-1:0] shift);
      drain_results();
      repeat (4) @(posedge clock);
      write_register(CSR_METER_ENABLED, CSR_DATA_WIDTH'(enable));
      write_register(CSR_ENERGY_UNIT_SHIFT, shift);
      stim_shift = shift;
   endtask

   // Most samples are well-formed steps whose energy delta spans the range up to
   // just above the saturation point; the rest are stalled clocks, backward time,
   // raw noise and large intervals, some of which wrap the shifted denominator to zero.
   task automatic send_random_sample();
      int unsigned             pick;
      logic [TIME_WIDTH-1:0]   delta_t;
      logic [63:0]             denom;
      logic [63:0]             energy_step;
      logic [ENERGY_WIDTH-1:0] energy;
      logic [TIME_WIDTH-1:0]   stamp;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         if ($urandom_range(0, 4) == 0) begin
            delta_t = 64'($urandom_range(1, 100000));
         end else begin
            delta_t = 64'($urandom_range(1, 2000));
         end
         denom       = delta_t << stim_shift;
         energy_step = 64'($urandom_range(0, 11000)) * denom / 64'd10000;
         if (energy_step > 64'hFFFF_FFFF) begin
            energy = $urandom;
         end else begin
            energy = last_energy + energy_step[ENERGY_WIDTH-1:0];
         end
         stamp = last_time + delta_t;
      end else if (pick < 78) begin
         energy = last_energy + $urandom;
         stamp  = last_time;
      end else if (pick < 84) begin
         energy = last_energy + $urandom_range(0, 100000);
         stamp  = last_time - 64'($urandom_range(1, 5000));
      end else if (pick < 92) begin
         energy = $urandom;
         stamp  = {$urandom, $urandom};
      end else begin
         if (pick < 96 && stim_shift != '0) begin
            delta_t = ({$urandom, $urandom} | 64'h1) << (64 - int'(stim_shift));
         end else begin
            delta_t = ({$urandom, $urandom} | 64'h1) << $urandom_range(20, 63);
         end
         energy = last_energy + $urandom;
         stamp  = last_time + delta_t;
      end
      send_sample(energy, stamp);
   endtask

   initial begin : stimulus
      int phase;
      int n;
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.energy_count = '0;
      req_if.time_ms      = '0;
      csr_if.valid        = 1'b0;
      csr_if.index        = CSR_METER_ENABLED;
      csr_if.data         = '0;
      burst_left          = 0;
      stim_shift          = '0;
      last_energy         = '0;
      last_time           = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Disabled after reset: nothing is stored and nothing primes.
      send_sample('1, '1);
      send_sample('0, '0);

      configure(1'b1, 5'd10);
      send_sample(32'd100, 64'd1000);
      send_sample(32'd100, 64'd1000);
      send_sample(32'd10340, 64'd2000);
      send_sample(32'hFFFF_FFF0, 64'd3000);
      send_sample(32'h0000_0010, 64'd4000);
      send_sample(32'h8000_0010, 64'd4001);
      send_sample(32'h8000_1000, 64'd2000);
      send_sample(32'h8000_2000, 64'd2000 + (64'd1 << 54));
      send_sample('0, '1);

      configure(1'b1, 5'd0);
      send_sample(32'd5000, 64'd16);
      send_sample(32'd9000, 64'd32);

      configure(1'b0, 5'd31);
      send_sample(32'd123, 64'd5);

      configure(1'b1, 5'd31);
      send_sample(32'd8999, 64'd33);
      send_sample(32'd9999, 64'd34);

      for (phase = 0; phase < 10; phase++) begin
         case (phase)
            0: configure(1'b1, 5'd31);
            1: configure(1'b1, 5'd1);
            2: configure(1'b0, 5'($urandom_range(0, 31)));
            3: configure(1'b1, 5'd0);
            4: configure(1'b1, 5'd16);
            default: configure($urandom_range(0, 7) != 0, 5'($urandom_range(0, 31)));
         endcase
         for (n = 0; n < 200; n++) begin
            if (n == 100 && (phase % 3) == 0) begin
               drain_results();
            end
            send_random_sample();
         end
      end

      drain_results();
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/emp_pkg.sv
hw/rtl/emp_req_if.sv
hw/rtl/emp_rsp_if.sv
hw/rtl/emp_csr_if.sv
hw/rtl/energy_counter_power_meter_top.sv
dv/power_meter_checker.sv
dv/tb.sv
